@@ src/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, operation and status codes, and the cell and result types
// of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 7;
  localparam int FILL_W     = 7;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_L = 3'd0,
    MODE_PUSH_R = 3'd1,
    MODE_POP_L  = 3'd2,
    MODE_POP_R  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED  = 3'd0,
    ST_POPPED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_R,
    OP_SHIFT_L,
    OP_APPEND,
    OP_TRIM,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    status_t                      status;
    logic signed [DATA_WIDTH-1:0] pop_value;
    logic [FILL_W-1:0]            fill_count;
  } result_t;

endpackage

@@ src/bdq_cell.sv @@
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the queue row: holds a word and an occupied flag, and takes
// its next contents from itself, a neighbour or the push value.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bdq_pkg::cell_op_t                    op,
  input  logic signed [bdq_pkg::DATA_WIDTH-1:0] push_value,
  input  logic signed [bdq_pkg::DATA_WIDTH-1:0] left_value,
  input  logic                                 left_occ,
  input  logic signed [bdq_pkg::DATA_WIDTH-1:0] right_value,
  input  logic                                 right_occ,
  output logic signed [bdq_pkg::DATA_WIDTH-1:0] value,
  output logic                                 occ
);

  logic is_gap_head;
  logic is_tail;

  assign is_gap_head = !occ && left_occ;
  assign is_tail     = occ && !right_occ;

  always_ff @(posedge clk) begin
    case (op)
      bdq_pkg::OP_SHIFT_R: value <= left_value;
      bdq_pkg::OP_SHIFT_L: value <= right_value;
      bdq_pkg::OP_APPEND: begin
        if (is_gap_head) begin
          value <= push_value;
        end
      end
      default: value <= value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      case (op)
        bdq_pkg::OP_SHIFT_R: occ <= left_occ;
        bdq_pkg::OP_SHIFT_L: occ <= right_occ;
        bdq_pkg::OP_APPEND: begin
          if (is_gap_head) begin
            occ <= 1'b1;
          end
        end
        bdq_pkg::OP_TRIM: begin
          if (is_tail) begin
            occ <= 1'b0;
          end
        end
        bdq_pkg::OP_CLEAR: occ <= 1'b0;
        default:           occ <= occ;
      endcase
    end
  end

endmodule

@@ src/bdq_out_buf.sv @@
// ----------------------------------------------------------------------------
// bdq_out_buf
// Result register with a skid stage, so a new item is taken while a
// finished result still waits on the output.
// ----------------------------------------------------------------------------
module bdq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bdq_pkg::result_t load_res,
  input  logic             out_stall,
  output logic             out_valid,
  output bdq_pkg::result_t out_res,
  output logic             busy
);

  logic             skid_valid;
  bdq_pkg::result_t skid_res;
  logic             out_fire;

  assign out_fire = out_valid && !out_stall;
  assign busy     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_fire) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (load) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (load) begin
      if (!out_valid || out_fire) begin
        out_res <= load_res;
      end else begin
        skid_res <= load_res;
      end
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_fire |=> out_valid && !skid_valid)
    else $error("skid stage did not move to output");

  a_no_drop : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

@@ src/bounded_deque.sv @@
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed words with a programmable capacity, built as
// a row of cells that shift together; the queue always fills a prefix of
// the row, left end at cell 0.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_stall  | mode, push_value
//   output   | out_valid / out_stall| status, pop_value, fill_count
//   config   | cfg_valid / cfg_ready| cfg_data (capacity)
//
// One operation per cycle while in_stall is low; the cell row updates on the
// accepting edge and the result is registered in the output or skid stage.
// A right pop selects the tail cell through an OR tree across the row.
// Input stalls only while the skid stage holds a second waiting result.
// Reset empties the row and sets the capacity to 64; config is always ready.
// ----------------------------------------------------------------------------
module bounded_deque (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bdq_pkg::MODE_W-1:0]            mode,
  input  logic signed [bdq_pkg::DATA_WIDTH-1:0] push_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bdq_pkg::STATUS_W-1:0]          status,
  output logic signed [bdq_pkg::DATA_WIDTH-1:0] pop_value,
  output logic [bdq_pkg::FILL_W-1:0]            fill_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]             cfg_data
);

  logic [bdq_pkg::CAP_W-1:0]             capacity;
  logic [bdq_pkg::CNT_W-1:0]             count;
  logic [bdq_pkg::CNT_W-1:0]             count_next;
  logic                                  in_fire;
  logic                                  full;
  logic                                  empty;
  bdq_pkg::mode_t                        mode_op;
  bdq_pkg::cell_op_t                     cell_op;
  bdq_pkg::result_t                      res;
  bdq_pkg::result_t                      out_res;
  logic                                  busy;
  logic signed [bdq_pkg::DATA_WIDTH-1:0] cell_value [bdq_pkg::DEPTH];
  logic [bdq_pkg::DEPTH-1:0]             occ;
  logic [bdq_pkg::DEPTH-1:0]             occ_r;
  logic signed [bdq_pkg::DATA_WIDTH-1:0] tail_value;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid && !in_stall;
  assign mode_op   = bdq_pkg::mode_t'(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bdq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  assign empty = (count == '0);
  assign full  = (bdq_pkg::CMP_W'(count) >= bdq_pkg::CMP_W'(capacity))
              || (count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));

  genvar gi;
  generate
    for (gi = 0; gi < bdq_pkg::DEPTH; gi++) begin : g_cell
      logic signed [bdq_pkg::DATA_WIDTH-1:0] lv;
      logic signed [bdq_pkg::DATA_WIDTH-1:0] rv;
      logic                                  lo;

      if (gi == 0) begin : g_left_end
        assign lv = push_value;
        assign lo = 1'b1;
      end else begin : g_left_mid
        assign lv = cell_value[gi-1];
        assign lo = occ[gi-1];
      end

      if (gi == bdq_pkg::DEPTH - 1) begin : g_right_end
        assign rv          = '0;
        assign occ_r[gi]   = 1'b0;
      end else begin : g_right_mid
        assign rv          = cell_value[gi+1];
        assign occ_r[gi]   = occ[gi+1];
      end

      bdq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .op          (cell_op),
        .push_value  (push_value),
        .left_value  (lv),
        .left_occ    (lo),
        .right_value (rv),
        .right_occ   (occ_r[gi]),
        .value       (cell_value[gi]),
        .occ         (occ[gi])
      );
    end
  endgenerate

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
      tail_value = tail_value
                 | (cell_value[i] & {bdq_pkg::DATA_WIDTH{occ[i] && !occ_r[i]}});
    end
  end

  always_comb begin
    cell_op       = bdq_pkg::OP_HOLD;
    count_next    = count;
    res.status    = bdq_pkg::ST_CLEARED;
    res.pop_value = '0;
    if (in_fire) begin
      unique case (mode_op) inside
        bdq_pkg::MODE_PUSH_L, bdq_pkg::MODE_PUSH_R: begin
          if (full) begin
            res.status = bdq_pkg::ST_FULL;
          end else begin
            cell_op    = (mode_op == bdq_pkg::MODE_PUSH_L) ? bdq_pkg::OP_SHIFT_R
                                                           : bdq_pkg::OP_APPEND;
            count_next = count + bdq_pkg::CNT_W'(1);
            res.status = bdq_pkg::ST_PUSHED;
          end
        end
        bdq_pkg::MODE_POP_L, bdq_pkg::MODE_POP_R: begin
          if (empty) begin
            res.status = bdq_pkg::ST_EMPTY;
          end else begin
            if (mode_op == bdq_pkg::MODE_POP_L) begin
              cell_op       = bdq_pkg::OP_SHIFT_L;
              res.pop_value = cell_value[0];
            end else begin
              cell_op       = bdq_pkg::OP_TRIM;
              res.pop_value = tail_value;
            end
            count_next = count - bdq_pkg::CNT_W'(1);
            res.status = bdq_pkg::ST_POPPED;
          end
        end
        bdq_pkg::MODE_CLEAR: begin
          cell_op    = bdq_pkg::OP_CLEAR;
          count_next = '0;
          res.status = bdq_pkg::ST_CLEARED;
        end
        default: begin
          cell_op    = bdq_pkg::OP_CLEAR;
          count_next = '0;
          res.status = bdq_pkg::ST_CLEARED;
        end
      endcase
    end
    res.fill_count = bdq_pkg::FILL_W'(count_next);
  end

  bdq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .load_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .busy      (busy)
  );

  assign status     = out_res.status;
  assign pop_value  = out_res.pop_value;
  assign fill_count = out_res.fill_count;

  a_occ_matches_count : assert property (@(posedge clk) disable iff (rst)
    bdq_pkg::CNT_W'($countones(occ)) == count)
    else $error("occupied cells disagree with entry count");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    in_fire && (mode == bdq_pkg::MODE_CLEAR) |=> (count == '0) && (occ == '0))
    else $error("clear left entries behind");

  a_full_push_holds : assert property (@(posedge clk) disable iff (rst)
    in_fire && full && ((mode == bdq_pkg::MODE_PUSH_L) || (mode == bdq_pkg::MODE_PUSH_R))
    |=> $stable(count) && $stable(occ))
    else $error("push on a full queue changed the row");

endmodule
